[hdl/cls_pkg.sv]
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants for the corner lock and smoothing block
// Holds the register indexes and the controller to datapath command and
// status structures.
// ----------------------------------------------------------------------------
package cls_pkg;

   localparam int NCOORD = 8;
   localparam int NCORNER = 4;

   localparam logic [0:0] REG_LOCK_THRESHOLD = 1'b0;
   localparam logic [0:0] REG_DECAY_WEIGHT = 1'b1;

   localparam logic [7:0] LOCK_THRESHOLD_RESET = 8'd8;
   localparam logic [15:0] DECAY_WEIGHT_RESET = 16'd52429;

   typedef struct packed {
      logic load;        // capture the raw request
      logic dist_start;  // start one corner distance
      logic dist_step;   // one root iteration
      logic dist_add;    // add finished distance to the sum
      logic decide;      // choose held or raw set and push history
      logic acc_clear;   // clear the weighted accumulators
      logic acc_step;    // add one history frame
      logic div_start;   // start the eight divisions
      logic div_step;    // one quotient bit
      logic out_load;    // move quotients to the output register
   } cls_cmd_type;

   typedef struct packed {
      logic held_valid;
      logic acc_last;    // frame being added is the oldest
   } cls_status_type;

endpackage

[hdl/cls_ctrl.sv]
// ----------------------------------------------------------------------------
// cls_ctrl: sequencer for the corner lock and smoothing block
// Steps the distance root, the history accumulation and the divider.
// ----------------------------------------------------------------------------
module cls_ctrl
   import cls_pkg::*;
#(
   parameter int ROOT_STEPS = 16,
   parameter int DIV_STEPS = 14
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  cls_status_type status,
   output cls_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIST = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_ACC = 3'd3;
   localparam logic [2:0] ST_DIV = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] corner_ff, corner_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // A new request may be taken while the previous result still waits.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      corner_in = corner_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIST;
               cnt_in = '0;
               corner_in = '0;
            end
         end
         ST_DIST: begin
            if (!status.held_valid) begin
               state_in = ST_DECIDE;
            end else if (cnt_ff == 5'd0) begin
               cmd.dist_start = 1'b1;
               cnt_in = 5'd1;
            end else if (cnt_ff <= 5'(ROOT_STEPS)) begin
               cmd.dist_step = 1'b1;
               cnt_in = cnt_ff + 5'd1;
            end else begin
               cmd.dist_add = 1'b1;
               cnt_in = '0;
               corner_in = corner_ff + 2'd1;
               if (corner_ff == 2'(NCORNER - 1)) state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            cmd.acc_clear = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_step = 1'b1;
            if (status.acc_last) state_in = ST_DIV;
            cnt_in = '0;
         end
         ST_DIV: begin
            if (cnt_ff == 5'd0) begin
               cmd.div_start = 1'b1;
               cnt_in = 5'd1;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'(DIV_STEPS)) state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         corner_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         corner_ff <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/cls_datapath.sv]
// ----------------------------------------------------------------------------
// cls_datapath: distance root, history store, accumulators and divider
// The distance root is shared by the four corners; all units are stepped by the controller.
// ----------------------------------------------------------------------------
module cls_datapath
   import cls_pkg::*;
#(
   parameter int HISTORY_DEPTH = 5,
   parameter int COORD_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cls_cmd_type                cmd,
   output cls_status_type             status,
   input  logic [NCOORD*COORD_BITS-1:0] req_data,
   input  logic [7:0]                 lock_threshold,
   input  logic [15:0]                decay_weight,
   output logic [NCOORD*COORD_BITS-1:0] rsp_data
);

   localparam int CB = COORD_BITS;
   localparam int HB = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNTB = $clog2(HISTORY_DEPTH + 1);
   localparam int RADB = 2 * CB + 2 + 16;          // radicand width
   localparam int ROOTB = RADB / 2 + 1;
   localparam int SUMB = ROOTB + 2;
   localparam int TOTB = 17 + CNTB;                 // sum of weights
   localparam int ACCB = CB + TOTB;                 // weighted coordinate sum
   localparam int NUMB = ACCB + 2;
   localparam int QB = CB + 2;                      // quotient bits examined

   logic [CB-1:0] raw_ff [NCOORD];
   logic [CB-1:0] held_ff [NCOORD];
   logic          held_valid_ff;
   logic [CB-1:0] hist_ff [HISTORY_DEPTH][NCOORD];
   logic [CNTB-1:0] count_ff;
   logic [HB-1:0]   newest_ff;
   logic [1:0]      corner_ff;

   // square root unit
   logic [RADB-1:0]  rad_ff;
   logic [ROOTB-1:0] root_ff;
   logic [RADB+1:0]  rem_ff;
   logic [SUMB-1:0]  dsum_ff;
   logic [CB-1:0]    dx, dy;
   logic [2*CB:0]    sq;

   // accumulation
   logic [ACCB-1:0] acc_ff [NCOORD];
   logic [TOTB-1:0] total_ff;
   logic [16:0]     w_ff;
   logic [CNTB-1:0] k_ff;
   logic [HB-1:0]   rd_ff;
   logic [32:0]     w_prod;

   // division
   logic [QB-1:0]   quo_ff [NCOORD];
   logic [NUMB-1:0] rem_d_ff [NCOORD];
   logic [CB-1:0]   out_ff [NCOORD];

   always_comb begin
      logic [CB-1:0] rx, ry, hx, hy;
      rx = raw_ff[{corner_ff, 1'b0}];
      ry = raw_ff[{corner_ff, 1'b1}];
      hx = held_ff[{corner_ff, 1'b0}];
      hy = held_ff[{corner_ff, 1'b1}];
      dx = (rx >= hx) ? rx - hx : hx - rx;
      dy = (ry >= hy) ? ry - hy : hy - ry;
      sq = (2*CB+1)'(dx) * (2*CB+1)'(dx) + (2*CB+1)'(dy) * (2*CB+1)'(dy);
   end

   assign w_prod = 33'(w_ff) * 33'(decay_weight);
   assign status.held_valid = held_valid_ff;
   assign status.acc_last = (k_ff == count_ff - CNTB'(1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < NCOORD; i++) raw_ff[i] <= req_data[i*CB +: CB];
         corner_ff <= '0;
         dsum_ff <= '0;
      end
      if (cmd.dist_start) begin
         rad_ff <= {{(RADB-2*CB-1-16){1'b0}}, sq, 16'd0};
         root_ff <= '0;
         rem_ff <= '0;
      end
      // Restoring root, two radicand bits per step.
      if (cmd.dist_step) begin
         logic [RADB+1:0] trial, r2;
         r2 = {rem_ff[RADB-1:0], rad_ff[RADB-1 -: 2]};
         trial = {root_ff, 2'b01};
         rad_ff <= {rad_ff[RADB-3:0], 2'b00};
         if (r2 >= trial) begin
            rem_ff <= r2 - trial;
            root_ff <= {root_ff[ROOTB-2:0], 1'b1};
         end else begin
            rem_ff <= r2;
            root_ff <= {root_ff[ROOTB-2:0], 1'b0};
         end
      end
      if (cmd.dist_add) begin
         dsum_ff <= dsum_ff + SUMB'(root_ff);
         corner_ff <= corner_ff + 2'd1;
      end
      if (cmd.acc_clear) begin
         for (int i = 0; i < NCOORD; i++) acc_ff[i] <= '0;
         total_ff <= '0;
         w_ff <= 17'h10000;
         k_ff <= '0;
         rd_ff <= (count_ff == '0) ? HB'(0)
                  : (32'(newest_ff) + 1 == HISTORY_DEPTH) ? HB'(0) : newest_ff + HB'(1);
      end
      if (cmd.acc_step) begin
         for (int i = 0; i < NCOORD; i++)
            acc_ff[i] <= acc_ff[i] + ACCB'(hist_ff[rd_ff][i]) * ACCB'(w_ff);
         total_ff <= total_ff + TOTB'(w_ff);
         w_ff <= w_prod[32:16];
         k_ff <= k_ff + CNTB'(1);
         rd_ff <= (rd_ff == '0) ? HB'(HISTORY_DEPTH - 1) : rd_ff - HB'(1);
      end
      if (cmd.out_load)
         for (int i = 0; i < NCOORD; i++) out_ff[i] <= (quo_ff[i] > QB'({CB{1'b1}})) ?
            {CB{1'b1}} : quo_ff[i][CB-1:0];
   end

   // Long division, one quotient bit per step from the top, one lane per
   // coordinate.
   logic [4:0] dcnt_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dcnt_ff <= 5'(QB - 1);
         for (int i = 0; i < NCOORD; i++) begin
            rem_d_ff[i] <= {acc_ff[i], 1'b0} + NUMB'(total_ff);
            quo_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 5'd1;
         for (int i = 0; i < NCOORD; i++) begin
            logic [NUMB+QB:0] dsh;
            dsh = (NUMB+QB+1)'({total_ff, 1'b0}) << dcnt_ff;
            if ((NUMB+QB+1)'(rem_d_ff[i]) >= dsh) begin
               rem_d_ff[i] <= NUMB'((NUMB+QB+1)'(rem_d_ff[i]) - dsh);
               quo_ff[i] <= {quo_ff[i][QB-2:0], 1'b1};
            end else begin
               quo_ff[i] <= {quo_ff[i][QB-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         count_ff <= '0;
         newest_ff <= '0;
      end else if (cmd.decide) begin
         logic lock;
         logic [HB-1:0] slot;
         lock = held_valid_ff &&
                (32'(dsum_ff) < ((32'(lock_threshold) * 4) << 8));
         slot = (count_ff == '0) ? HB'(0)
                : (32'(newest_ff) + 1 == HISTORY_DEPTH) ? HB'(0) : newest_ff + HB'(1);
         for (int i = 0; i < NCOORD; i++) begin
            hist_ff[slot][i] <= lock ? held_ff[i] : raw_ff[i];
            if (!lock) held_ff[i] <= raw_ff[i];
         end
         held_valid_ff <= 1'b1;
         newest_ff <= slot;
         if (32'(count_ff) < HISTORY_DEPTH) count_ff <= count_ff + CNTB'(1);
      end
   end

   always_comb
      for (int i = 0; i < NCOORD; i++) rsp_data[i*CB +: CB] = out_ff[i];

endmodule

[hdl/corner_lock_and_smooth_top.sv]
// ----------------------------------------------------------------------------
// corner_lock_and_smooth_top: deadband hold and weighted history smoothing
// Holds a quadrilateral's corners still under small movement and averages
// the recent frames with decaying weights.
// ----------------------------------------------------------------------------
// A request carries four raw corners; one response carries four smoothed
// corners. csr_ index 0 writes lock_threshold and index 1 writes decay_weight;
// other indexes are ignored. Writes are always taken.
// With a held set, four distance roots (each a start, the root steps and
// an add) come first, then one decision step, one accumulation step per
// stored frame (up to HISTORY_DEPTH), the eight-lane bit-serial divider
// and one output step; for the first request after reset, with no held
// set, the distance roots are skipped.
// One request is processed at a time; the next is accepted in the cycle
// after the response is loaded.
// A new request is accepted while a finished response still waits; if the
// receiver stalls, the next response waits in the sequencer until the
// output register is free. Reset clears the held set, the history and the
// registers to their defaults.
// ----------------------------------------------------------------------------
module corner_lock_and_smooth_top
   import cls_pkg::*;
#(
   parameter int HISTORY_DEPTH = 5,
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_c0_x, req_c0_y, req_c1_x, req_c1_y,
   input  logic [COORD_BITS-1:0] req_c2_x, req_c2_y, req_c3_x, req_c3_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_s0_x, rsp_s0_y, rsp_s1_x, rsp_s1_y,
   output logic [COORD_BITS-1:0] rsp_s2_x, rsp_s2_y, rsp_s3_x, rsp_s3_y,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [15:0]           csr_data
);

   localparam int CB = COORD_BITS;
   localparam int RSTEPS = (2 * CB + 2 + 16) / 2;

   cls_cmd_type    cmd;
   cls_status_type status;
   logic [7:0]  lock_threshold_ff;
   logic [15:0] decay_weight_ff;
   logic [NCOORD*CB-1:0] req_data, rsp_data;

   assign csr_ready = 1'b1;
   assign req_data = {req_c3_y, req_c3_x, req_c2_y, req_c2_x,
                      req_c1_y, req_c1_x, req_c0_y, req_c0_x};
   assign {rsp_s3_y, rsp_s3_x, rsp_s2_y, rsp_s2_x,
           rsp_s1_y, rsp_s1_x, rsp_s0_y, rsp_s0_x} = rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_threshold_ff <= LOCK_THRESHOLD_RESET;
         decay_weight_ff <= DECAY_WEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LOCK_THRESHOLD: lock_threshold_ff <= csr_data[7:0];
            REG_DECAY_WEIGHT:   decay_weight_ff <= csr_data;
            default: ;
         endcase
      end
   end

   cls_ctrl #(.ROOT_STEPS(RSTEPS), .DIV_STEPS(CB + 2)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   cls_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .COORD_BITS(COORD_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_data(req_data), .lock_threshold(lock_threshold_ff),
      .decay_weight(decay_weight_ff), .rsp_data(rsp_data)
   );

endmodule

[hdl/cls_checker.sv]
// ----------------------------------------------------------------------------
// cls_checker: port-level checks for the corner lock and smoothing block
// Watches the handshakes seen at the top level.
// ----------------------------------------------------------------------------
module cls_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_ready
);

   // A response stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   // After a request is accepted, no new request is taken in the next cycle.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("request overlap");

   // Nothing is offered straight after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("response after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("configuration stalled");

endmodule

bind corner_lock_and_smooth_top cls_checker u_cls_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .csr_ready(csr_ready)
);

[tb/corner_lock_and_smooth_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// corner_lock_and_smooth_top_test: self-checking bench for corner smoothing
// Drives corner requests with random gaps, predicts the deadband hold and the
// decaying weighted average of the history, and checks every response.
// ----------------------------------------------------------------------------
module corner_lock_and_smooth_top_test
   import cls_pkg::*;
();

   localparam int HISTORY_DEPTH = 5;
   localparam int COORD_BITS = 12;
   localparam int SETTLE_CYCLES = 120;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef logic [COORD_BITS-1:0] coord_set_type [NCOORD];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [COORD_BITS-1:0] req_c [NCOORD];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [COORD_BITS-1:0] rsp_s [NCOORD];
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = REG_LOCK_THRESHOLD;
   logic [15:0] csr_data = '0;

   // predictor state
   logic [7:0] lock_threshold_q;
   logic [15:0] decay_weight_q;
   bit held_valid_q;
   logic [COORD_BITS-1:0] held_q [NCOORD];
   logic [COORD_BITS-1:0] history_q [HISTORY_DEPTH][NCOORD];
   int history_count_q;
   int history_newest_q;

   // Expected responses, keyed by request number.
   coord_set_type expected_store [int];
   int sent_count = 0;
   int checked_count = 0;
   int error_count = 0;
   int idle_cycles = 0;
   bit rsp_stall_long = 1'b0;

   initial begin
      foreach (req_c[i]) req_c[i] = '0;
   end

   corner_lock_and_smooth_top #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_c0_x(req_c[0]), .req_c0_y(req_c[1]), .req_c1_x(req_c[2]), .req_c1_y(req_c[3]),
      .req_c2_x(req_c[4]), .req_c2_y(req_c[5]), .req_c3_x(req_c[6]), .req_c3_y(req_c[7]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_s0_x(rsp_s[0]), .rsp_s0_y(rsp_s[1]), .rsp_s1_x(rsp_s[2]), .rsp_s1_y(rsp_s[3]),
      .rsp_s2_x(rsp_s[4]), .rsp_s2_y(rsp_s[5]), .rsp_s3_x(rsp_s[6]), .rsp_s3_y(rsp_s[7]),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // Deadband decision, history push and weighted mean for one request.
   function automatic coord_set_type smooth_corners(coord_set_type raw);
      longint unsigned dist_sum, dx, dy, w, total;
      longint unsigned acc [NCOORD];
      longint unsigned q;
      coord_set_type result;
      int slot, idx;
      bit keep_held;
      keep_held = 1'b0;
      if (held_valid_q) begin
         dist_sum = 0;
         for (int c = 0; c < NCORNER; c++) begin
            dx = raw[2*c] >= held_q[2*c] ? raw[2*c] - held_q[2*c] : held_q[2*c] - raw[2*c];
            dy = raw[2*c+1] >= held_q[2*c+1] ? raw[2*c+1] - held_q[2*c+1]
                                             : held_q[2*c+1] - raw[2*c+1];
            dist_sum += isqrt((dx*dx + dy*dy) << 16);
         end
         keep_held = dist_sum < ((longint'(lock_threshold_q) * 4) << 8);
      end
      if (!keep_held) begin
         held_q = raw;
         held_valid_q = 1'b1;
      end
      slot = history_count_q == 0 ? 0 : (history_newest_q + 1) % HISTORY_DEPTH;
      history_q[slot] = held_q;
      history_newest_q = slot;
      if (history_count_q < HISTORY_DEPTH) history_count_q++;
      foreach (acc[i]) acc[i] = 0;
      w = 65536;
      total = 0;
      for (int k = 0; k < history_count_q; k++) begin
         idx = (history_newest_q + HISTORY_DEPTH - k) % HISTORY_DEPTH;
         for (int i = 0; i < NCOORD; i++) acc[i] += longint'(history_q[idx][i]) * w;
         total += w;
         w = (w * decay_weight_q) >> 16;
      end
      for (int i = 0; i < NCOORD; i++) begin
         q = (2*acc[i] + total) / (2*total);
         if (q > (1 << COORD_BITS) - 1) q = (1 << COORD_BITS) - 1;
         result[i] = q[COORD_BITS-1:0];
      end
      return result;
   endfunction

   // Response checker and receiver-side stalls.
   always @(posedge clock) begin
      coord_set_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (checked_count == sent_count) begin
               $display("%0t: response with no request outstanding", $time);
               error_count++;
            end else begin
               want = expected_store[checked_count];
               expected_store.delete(checked_count);
               checked_count++;
               for (int i = 0; i < NCOORD; i++)
                  if (rsp_s[i] !== want[i]) begin
                     $display("%0t: coord %0d expected %0d actual %0d",
                              $time, i, want[i], rsp_s[i]);
                     error_count++;
                  end
            end
         end
         if (rsp_stall_long) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(0, 99) < 70);
      end
   end

   // Occasional long receiver stalls.
   initial begin
      forever begin
         repeat ($urandom_range(200, 3000)) @(posedge clock);
         rsp_stall_long = 1'b1;
         repeat ($urandom_range(20, 300)) @(posedge clock);
         rsp_stall_long = 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_corners(coord_set_type raw);
      repeat (gap_length()) @(posedge clock);
      req_valid <= 1'b1;
      foreach (raw[i]) req_c[i] <= raw[i];
      do @(posedge clock); while (!req_ready);
      expected_store[sent_count] = smooth_corners(raw);
      sent_count++;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (checked_count != sent_count) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] index, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_LOCK_THRESHOLD) lock_threshold_q = value[7:0];
      else decay_weight_q = value;
      @(posedge clock);
   endtask

   function automatic coord_set_type random_set();
      coord_set_type s;
      foreach (s[i]) s[i] = COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      return s;
   endfunction

   // Moves each coordinate of a base set by up to spread pixels.
   function automatic coord_set_type jitter(coord_set_type base, int spread);
      coord_set_type s;
      int v;
      foreach (s[i]) begin
         v = int'(base[i]) + $urandom_range(0, 2*spread) - spread;
         if (v < 0) v = 0;
         if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
         s[i] = v[COORD_BITS-1:0];
      end
      return s;
   endfunction

   task automatic test_directed();
      coord_set_type s;
      foreach (s[i]) s[i] = '0;
      send_corners(s);
      foreach (s[i]) s[i] = '1;
      send_corners(s);
      send_corners(s);
      s[0] = s[0] - 1'b1;
      send_corners(s);
      foreach (s[i]) s[i] = (i % 2) ? '1 : '0;
      send_corners(s);
      foreach (s[i]) s[i] = (i % 2) ? 12'haaa : 12'h555;
      send_corners(s);
      send_corners(jitter(s, 3));
      send_corners(jitter(s, 40));
      drain();
      // Zero decay: only the newest frame counts; zero threshold never holds.
      write_register(REG_DECAY_WEIGHT, 16'd0);
      write_register(REG_LOCK_THRESHOLD, 16'd0);
      send_corners(s);
      send_corners(s);
      send_corners(jitter(s, 1));
      send_corners(random_set());
      drain();
      write_register(REG_DECAY_WEIGHT, 16'hffff);
      write_register(REG_LOCK_THRESHOLD, 16'h00ff);
      send_corners(s);
      send_corners(jitter(s, 200));
      send_corners(random_set());
      foreach (s[i]) s[i] = '0;
      send_corners(s);
      drain();
   endtask

   task automatic test_random();
      coord_set_type base;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(REG_LOCK_THRESHOLD, 16'(LOCK_THRESHOLD_RESET));
               write_register(REG_DECAY_WEIGHT, DECAY_WEIGHT_RESET);
            end
            1: begin
               write_register(REG_LOCK_THRESHOLD, 16'd1);
               write_register(REG_DECAY_WEIGHT, 16'd1);
            end
            default: begin
               write_register(REG_LOCK_THRESHOLD, 16'($urandom_range(0, 255)));
               write_register(REG_DECAY_WEIGHT, 16'($urandom_range(0, 65535)));
            end
         endcase
         base = random_set();
         for (int n = 0; n < 105; n++) begin
            if ($urandom_range(0, 99) < 75) base = jitter(base, $urandom_range(0, 12));
            else base = random_set();
            send_corners(base);
         end
         drain();
      end
   endtask

   initial begin
      lock_threshold_q = LOCK_THRESHOLD_RESET;
      decay_weight_q = DECAY_WEIGHT_RESET;
      held_valid_q = 1'b0;
      history_count_q = 0;
      history_newest_q = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[corner_lock_and_smooth_top.f]
hdl/cls_pkg.sv
hdl/cls_ctrl.sv
hdl/cls_datapath.sv
hdl/corner_lock_and_smooth_top.sv
hdl/cls_checker.sv
tb/corner_lock_and_smooth_top_test.sv
